### hw/rtl/lspp_pkg.sv
package lspp_pkg;

   localparam int LSPP_MAX_WIDTH = 1024;
   localparam int DATA_W         = 32;
   localparam int BW_W           = 11;
   localparam int BH_W           = 16;
   localparam int ADDR_W         = 4;

   typedef enum logic [1:0] {
      REG_DECODE_MODE  = 2'd0,
      REG_BLOCK_WIDTH  = 2'd1,
      REG_BLOCK_HEIGHT = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic            decode_mode;
      logic [BW_W-1:0] block_width;
      logic [BH_W-1:0] block_height;
   } cfg_type;

   typedef struct packed {
      logic x_zero;
      logic y_zero;
      logic x_ge2;
      logic y_ge2;
   } pos_type;

   typedef struct packed {
      logic [DATA_W-1:0] w;
      logic [DATA_W-1:0] ww;
      logic [DATA_W-1:0] n;
      logic [DATA_W-1:0] nn;
      logic [DATA_W-1:0] nw;
      logic [DATA_W-1:0] nww;
      logic [DATA_W-1:0] nnw;
   } nbr_type;

   // signed halving, truncating toward zero
   function automatic logic [DATA_W-1:0] half_trunc(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] t;
      t = v + {{(DATA_W-1){1'b0}}, v[DATA_W-1]};
      return {t[DATA_W-1], t[DATA_W-1:1]};
   endfunction

endpackage

### hw/rtl/lspp_csr.sv
module lspp_csr
   import lspp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;

   assign idx    = reg_idx_type'(paddr[3:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite && pready) begin
         unique case (idx)
            REG_DECODE_MODE:  cfg_in.decode_mode  = pwdata[0];
            REG_BLOCK_WIDTH:  cfg_in.block_width  = pwdata[BW_W-1:0];
            REG_BLOCK_HEIGHT: cfg_in.block_height = pwdata[BH_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_DECODE_MODE:  prdata = {31'd0, cfg_ff.decode_mode};
         REG_BLOCK_WIDTH:  prdata = {{(32-BW_W){1'b0}}, cfg_ff.block_width};
         REG_BLOCK_HEIGHT: prdata = {{(32-BH_W){1'b0}}, cfg_ff.block_height};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decode_mode  <= 1'b0;
         cfg_ff.block_width  <= BW_W'(1024);
         cfg_ff.block_height <= BH_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/lspp_line_mem.sv
module lspp_line_mem
   import lspp_pkg::*;
#(
   parameter int DEPTH = LSPP_MAX_WIDTH,
   parameter int AW    = $clog2(LSPP_MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [2*DATA_W-1:0] wr_data,
   input  logic [AW-1:0]       rd_addr,
   output logic [2*DATA_W-1:0] rd_data
);

   logic [2*DATA_W-1:0] mem [DEPTH];
   logic [2*DATA_W-1:0] rd_raw_ff;
   logic [2*DATA_W-1:0] byp_data_ff;
   logic                byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_raw_ff <= mem[rd_addr];
   end

   // same-address read and write (one-column rows): forward the new word
   always_ff @(posedge clock) begin
      byp_ff      <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= wr_data;
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_raw_ff;

endmodule

### hw/rtl/lspp_predict.sv
module lspp_predict
   import lspp_pkg::*;
(
   input  pos_type           pos,
   input  nbr_type           nbr,
   output logic [DATA_W-1:0] pred
);

   logic [DATA_W-1:0] ww_s;
   logic [DATA_W-1:0] nn_s;
   logic [DATA_W-1:0] nww_s;
   logic [DATA_W-1:0] nnw_s;
   logic [DATA_W-1:0] dx;
   logic [DATA_W-1:0] dy;

   // missing second neighbors fall back to the first one (zero slope)
   assign ww_s  = pos.x_ge2 ? nbr.ww  : nbr.w;
   assign nn_s  = pos.y_ge2 ? nbr.nn  : nbr.n;
   assign nww_s = pos.x_ge2 ? nbr.nww : nbr.nw;
   assign nnw_s = pos.y_ge2 ? nbr.nnw : nbr.nw;

   assign dx = half_trunc((nbr.w - ww_s) + (nbr.nw - nww_s));
   assign dy = half_trunc((nbr.n - nn_s) + (nbr.nw - nnw_s));

   always_comb begin
      if (pos.x_zero && pos.y_zero) begin
         pred = '0;
      end else if (pos.y_zero) begin
         pred = nbr.w + (nbr.w - ww_s);
      end else if (pos.x_zero) begin
         pred = nbr.n + (nbr.n - nn_s);
      end else begin
         pred = half_trunc(nbr.w + dx + nbr.n + dy);
      end
   end

endmodule

### hw/rtl/local_slope_pixel_predictor_top.sv
// Lossless slope predictor: takes one sample (encode) or residual (decode) per
// cycle in row-major order and returns one residual or reconstruction per sample
// from the output register after acceptance; block_last marks the last sample of
// the block. Sustained rate is one transaction per clock while rsp_ready is high.
// The line store is a single MAX_WIDTH x 64 memory holding the two rows above; its
// word for the next column is prefetched when the column counter advances, so the
// prediction adders see registered neighbors only. No clearing pass after reset:
// line-store words read before being written in a block are undefined.
module local_slope_pixel_predictor_top
   import lspp_pkg::*;
#(
   parameter int MAX_WIDTH = LSPP_MAX_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_value_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_value_out,
   output logic              rsp_block_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CW    = (COL_W + 1 > BW_W) ? COL_W + 1 : BW_W;
   localparam int HW    = BH_W + 1;

   cfg_type             cfg;
   logic                in_acc;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [BH_W-1:0]     row_ff, row_in;
   logic [DATA_W-1:0]   west_ff, ww_ff, nw_ff, nww_ff, nnw_ff;
   logic [2*DATA_W-1:0] line_word;
   logic [DATA_W-1:0]   pred, result, sample;
   logic [CW-1:0]       width_eff;
   logic [HW-1:0]       height_eff;
   logic                row_end, last;
   logic                out_valid_ff;
   logic [DATA_W-1:0]   out_value_ff;
   logic                out_last_ff;
   pos_type             pos;
   nbr_type             nbr;

   lspp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ready = !out_valid_ff || rsp_ready;
   assign in_acc    = req_valid && req_ready;

   // effective geometry
   always_comb begin
      if (cfg.block_width == '0) begin
         width_eff = CW'(1);
      end else if (CW'(cfg.block_width) > CW'(MAX_WIDTH)) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = CW'(cfg.block_width);
      end
      height_eff = (cfg.block_height == '0) ? HW'(1) : HW'(cfg.block_height);
   end

   assign row_end = (CW'(col_ff) + CW'(1)) >= width_eff;
   assign last    = row_end && ((HW'(row_ff) + HW'(1)) >= height_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (reset) begin
         col_in = '0;
         row_in = '0;
      end else if (in_acc) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + BH_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // low half: row above, high half: two rows above
   lspp_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (COL_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (in_acc),
      .wr_addr (col_ff),
      .wr_data ({line_word[DATA_W-1:0], sample}),
      .rd_addr (col_in),
      .rd_data (line_word)
   );

   assign pos.x_zero = (col_ff == '0);
   assign pos.y_zero = (row_ff == '0);
   assign pos.x_ge2  = (CW'(col_ff) >= CW'(2));
   assign pos.y_ge2  = (row_ff >= BH_W'(2));

   assign nbr.w   = west_ff;
   assign nbr.ww  = ww_ff;
   assign nbr.n   = line_word[DATA_W-1:0];
   assign nbr.nn  = line_word[2*DATA_W-1:DATA_W];
   assign nbr.nw  = nw_ff;
   assign nbr.nww = nww_ff;
   assign nbr.nnw = nnw_ff;

   lspp_predict u_predict (
      .pos  (pos),
      .nbr  (nbr),
      .pred (pred)
   );

   assign result = cfg.decode_mode ? (req_value_in + pred) : (req_value_in - pred);
   assign sample = cfg.decode_mode ? result : req_value_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         west_ff      <= '0;
         ww_ff        <= '0;
         nw_ff        <= '0;
         nww_ff       <= '0;
         nnw_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (in_acc) begin
            west_ff <= sample;
            ww_ff   <= west_ff;
            nw_ff   <= nbr.n;
            nww_ff  <= nw_ff;
            nnw_ff  <= nbr.nn;
         end
         if (in_acc) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         out_value_ff <= result;
         out_last_ff  <= last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_value_out  = out_value_ff;
   assign rsp_block_last = out_last_ff;

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      in_acc && last |=> (col_ff == '0) && (row_ff == '0))
      else $error("position not cleared after last sample of block");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled while output register empty");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      in_acc |=> rsp_valid && (rsp_block_last == $past(last)))
      else $error("accepted transaction did not reach output register");

endmodule
